FILE: rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMP(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define ASSERT_NXT(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error(msg);

`endif

FILE: rtl/psf_pkg.sv
package psf_pkg;

    localparam int MAX_CORNERS = 32;
    localparam int COORD_BITS  = 16;
    localparam int IDX_W       = $clog2(MAX_CORNERS);
    localparam int CNT_W       = IDX_W + 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_ROW    = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    localparam logic [1:0] CFG_CLIP_LEFT  = 2'd0;
    localparam logic [1:0] CFG_CLIP_RIGHT = 2'd1;
    localparam logic [1:0] CFG_FILL_COLOR = 2'd2;

    typedef struct packed {
        logic [1:0]                    op;
        logic signed [COORD_BITS-1:0]  x;
        logic signed [COORD_BITS-1:0]  y;
    } t_cmd;

    typedef struct packed {
        logic signed [15:0] clip_left;
        logic signed [15:0] clip_right;
        logic [31:0]        fill_color;
    } t_cfg;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] span_start;
        logic signed [COORD_BITS-1:0] span_end;
        logic signed [COORD_BITS-1:0] row_y;
        logic [31:0]                  color;
        logic                         has_span;
        logic                         last;
        logic                         overflow;
    } t_result;

endpackage

FILE: rtl/psf_front.sv
module psf_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  logic [1:0]     i_op,
    input  logic signed [psf_pkg::COORD_BITS-1:0] i_x,
    input  logic signed [psf_pkg::COORD_BITS-1:0] i_y,
    output logic           o_cmd_valid,
    output psf_pkg::t_cmd  o_cmd,
    input  logic           i_cmd_pop
);
    import psf_pkg::*;

    t_cmd              r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QPTR_W:0]   r_fill;
    logic              push, pop;

    // unused op code is taken and dropped here
    assign o_stall     = (r_fill == (QPTR_W+1)'(QUEUE_DEPTH));
    assign push        = i_valid && !o_stall && (i_op != OP_NONE);
    assign pop         = i_cmd_pop && o_cmd_valid;
    assign o_cmd_valid = (r_fill != '0);
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= '{op: i_op, x: i_x, y: i_y};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_fill <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop)  r_rp <= r_rp + 1'b1;
            if (push && !pop)      r_fill <= r_fill + 1'b1;
            else if (pop && !push) r_fill <= r_fill - 1'b1;
        end
    end

endmodule

FILE: rtl/psf_back.sv
module psf_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_valid,
    input  psf_pkg::t_cmd    i_cmd,
    output logic             o_cmd_pop,
    input  psf_pkg::t_cfg    i_cfg,
    output logic             o_valid,
    input  logic             i_stall,
    output psf_pkg::t_result o_res
);
    import psf_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0,  S_PREV = 4'd1,  S_EDGE = 4'd2,  S_MUL = 4'd3,
                           S_SUM  = 4'd4,  S_DIV  = 4'd5,  S_INSR = 4'd6,  S_INSC = 4'd7,
                           S_NEXT = 4'd8,  S_PAIR = 4'd9,  S_PA   = 4'd10, S_PB   = 4'd11,
                           S_FIN  = 4'd12;
    localparam int DIV_STEPS = 35;

    logic [3:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_total, n_total;
    logic              r_ovf, n_ovf;
    logic [IDX_W-1:0]  r_i, n_i;
    logic [CNT_W-1:0]  r_cnt, n_cnt, r_j, n_j, r_pi, n_pi;
    logic [5:0]        r_dcnt, n_dcnt;

    logic signed [15:0] r_px, n_px, r_py, n_py, r_cx, n_cx, r_cy, n_cy, r_y, n_y;
    logic signed [15:0] r_xi, n_xi, r_val, n_val, r_a, n_a;
    logic signed [16:0] r_dy, n_dy, r_dx, n_dx;
    logic [15:0]        r_d, n_d;
    logic               r_dneg, n_dneg, r_qneg, n_qneg;
    logic signed [33:0] r_prod, n_prod;
    logic signed [32:0] r_xd, n_xd;
    logic [16:0]        r_rem, n_rem;
    logic [34:0]        r_quo, n_quo;
    logic               r_pv, n_pv;
    logic signed [15:0] r_ps, n_ps, r_pe, n_pe;

    logic               r_ov, n_ov;
    t_result            r_res, n_res;

    // memories
    logic signed [15:0] r_vx [MAX_CORNERS];
    logic signed [15:0] r_vy [MAX_CORNERS];
    logic signed [15:0] r_cm [MAX_CORNERS];
    logic signed [15:0] r_rdx, r_rdy, r_crd;
    logic [IDX_W-1:0]   vaddr, caddr, cwaddr;
    logic               vwe, cwe;
    logic signed [15:0] cwdata;

    logic               out_free, edge_hit;
    logic signed [16:0] d17;
    logic signed [35:0] tot, n_eff;
    logic [35:0]        tabs;
    logic [17:0]        shl, dv;
    logic [15:0]        q16;
    logic signed [15:0] ac, bc;
    logic [CNT_W:0]     pi1;

    assign out_free = !r_ov || !i_stall;
    assign o_valid  = r_ov;
    assign o_res    = r_res;

    always_ff @(posedge i_clk) begin
        if (vwe) begin
            r_vx[r_total[IDX_W-1:0]] <= i_cmd.x;
            r_vy[r_total[IDX_W-1:0]] <= i_cmd.y;
        end
        r_rdx <= r_vx[vaddr];
        r_rdy <= r_vy[vaddr];
    end

    always_ff @(posedge i_clk) begin
        if (cwe) r_cm[cwaddr] <= cwdata;
        r_crd <= r_cm[caddr];
    end

    always_comb begin
        n_state = r_state; n_total = r_total; n_ovf = r_ovf; n_i = r_i;
        n_cnt = r_cnt; n_j = r_j; n_pi = r_pi; n_dcnt = r_dcnt;
        n_px = r_px; n_py = r_py; n_cx = r_cx; n_cy = r_cy; n_y = r_y;
        n_xi = r_xi; n_val = r_val; n_a = r_a; n_dy = r_dy; n_dx = r_dx;
        n_d = r_d; n_dneg = r_dneg; n_qneg = r_qneg; n_prod = r_prod; n_xd = r_xd;
        n_rem = r_rem; n_quo = r_quo; n_pv = r_pv; n_ps = r_ps; n_pe = r_pe;
        n_ov = r_ov; n_res = r_res;
        o_cmd_pop = 1'b0; vwe = 1'b0; cwe = 1'b0;
        vaddr = r_i; caddr = r_pi[IDX_W-1:0];
        cwaddr = r_j[IDX_W-1:0]; cwdata = r_val;

        if (r_ov && !i_stall) n_ov = 1'b0;

        edge_hit = ((r_rdy < r_y) && (r_py >= r_y)) || ((r_py < r_y) && (r_rdy >= r_y));
        d17   = 17'(r_py) - 17'(r_rdy);
        n_eff = r_dneg ? -36'(r_prod) : 36'(r_prod);
        tot   = (36'(r_xd) <<< 1) + (n_eff <<< 1) + 36'($signed({1'b0, r_d}));
        tabs  = tot[35] ? 36'(-tot) : 36'(tot);
        shl   = {r_rem, r_quo[34]};
        dv    = {1'b0, r_d, 1'b0};
        q16   = r_quo[15:0];
        pi1   = (CNT_W+1)'(r_pi) + 1'b1;
        ac    = (r_a < i_cfg.clip_left) ? i_cfg.clip_left : r_a;
        bc    = (r_crd > i_cfg.clip_right) ? i_cfg.clip_right : r_crd;

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    case (i_cmd.op)
                        OP_CLEAR: begin
                            n_total = '0;
                            n_ovf   = 1'b0;
                        end
                        OP_APPEND: begin
                            if (r_total < CNT_W'(MAX_CORNERS)) begin
                                vwe     = 1'b1;
                                n_total = r_total + 1'b1;
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                        OP_ROW: begin
                            n_y   = i_cmd.y;
                            n_cnt = '0;
                            n_pi  = '0;
                            n_pv  = 1'b0;
                            n_i   = '0;
                            vaddr = IDX_W'(r_total - 1'b1);
                            n_state = (r_total == '0) ? S_FIN : S_PREV;
                        end
                        default: ;
                    endcase
                end
            end
            S_PREV: begin
                n_px = r_rdx; n_py = r_rdy;
                vaddr = '0;
                n_state = S_EDGE;
            end
            S_EDGE: begin
                if (edge_hit && (r_cnt < CNT_W'(MAX_CORNERS))) begin
                    n_cx = r_rdx; n_cy = r_rdy;
                    n_xi = r_rdx;
                    n_dneg = d17[16];
                    n_d  = d17[16] ? 16'(-d17) : 16'(d17);
                    n_dy = 17'(r_y) - 17'(r_rdy);
                    n_dx = 17'(r_px) - 17'(r_rdx);
                    n_state = S_MUL;
                end else begin
                    n_px = r_rdx; n_py = r_rdy;
                    if (CNT_W'(r_i) == r_total - 1'b1) begin
                        n_state = S_PAIR;
                    end else begin
                        n_i   = r_i + 1'b1;
                        vaddr = r_i + 1'b1;
                    end
                end
            end
            S_MUL: begin
                n_prod  = r_dy * r_dx;
                n_xd    = r_xi * $signed({1'b0, r_d});
                n_state = S_SUM;
            end
            S_SUM: begin
                n_qneg  = tot[35];
                n_quo   = tabs[34:0];
                n_rem   = '0;
                n_dcnt  = 6'(DIV_STEPS);
                n_state = S_DIV;
            end
            S_DIV: begin
                if (r_dcnt != '0) begin
                    if (shl >= dv) begin
                        n_rem = 17'(shl - dv);
                        n_quo = {r_quo[33:0], 1'b1};
                    end else begin
                        n_rem = shl[16:0];
                        n_quo = {r_quo[33:0], 1'b0};
                    end
                    n_dcnt = r_dcnt - 1'b1;
                end else begin
                    n_val   = r_qneg ? $signed(-q16) : $signed(q16);
                    n_j     = r_cnt;
                    n_state = S_INSR;
                end
            end
            S_INSR: begin
                if (r_j == '0) begin
                    cwe     = 1'b1;
                    n_cnt   = r_cnt + 1'b1;
                    n_state = S_NEXT;
                end else begin
                    caddr   = IDX_W'(r_j - 1'b1);
                    n_state = S_INSC;
                end
            end
            S_INSC: begin
                cwe = 1'b1;
                if (r_crd > r_val) begin
                    cwdata  = r_crd;
                    n_j     = r_j - 1'b1;
                    n_state = S_INSR;
                end else begin
                    n_cnt   = r_cnt + 1'b1;
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                n_px = r_cx; n_py = r_cy;
                if (CNT_W'(r_i) == r_total - 1'b1) begin
                    n_state = S_PAIR;
                end else begin
                    n_i     = r_i + 1'b1;
                    vaddr   = r_i + 1'b1;
                    n_state = S_EDGE;
                end
            end
            S_PAIR: begin
                if (pi1 < (CNT_W+1)'(r_cnt)) begin
                    caddr   = r_pi[IDX_W-1:0];
                    n_state = S_PA;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_PA: begin
                n_a     = r_crd;
                caddr   = pi1[IDX_W-1:0];
                n_state = S_PB;
            end
            S_PB: begin
                caddr = pi1[IDX_W-1:0];
                if (r_a >= i_cfg.clip_right) begin
                    n_state = S_FIN;
                end else if (r_crd > i_cfg.clip_left) begin
                    if (!r_pv || out_free) begin
                        if (r_pv) begin
                            n_ov  = 1'b1;
                            n_res = '{span_start: r_ps, span_end: r_pe, row_y: r_y,
                                      color: i_cfg.fill_color, has_span: 1'b1,
                                      last: 1'b0, overflow: r_ovf};
                        end
                        n_pv = 1'b1;
                        n_ps = (ac > bc) ? bc : ac;
                        n_pe = (ac > bc) ? ac : bc;
                        n_pi = r_pi + 2'd2;
                        n_state = S_PAIR;
                    end
                end else begin
                    n_pi    = r_pi + 2'd2;
                    n_state = S_PAIR;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_ov  = 1'b1;
                    n_res = '{span_start: r_pv ? r_ps : 16'sd0,
                              span_end: r_pv ? r_pe : 16'sd0, row_y: r_y,
                              color: i_cfg.fill_color, has_span: r_pv,
                              last: 1'b1, overflow: r_ovf};
                    n_pv    = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_total <= '0;
            r_ovf   <= 1'b0;
            r_pv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_total <= n_total;
            r_ovf   <= n_ovf;
            r_pv    <= n_pv;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i <= n_i; r_cnt <= n_cnt; r_j <= n_j; r_pi <= n_pi; r_dcnt <= n_dcnt;
        r_px <= n_px; r_py <= n_py; r_cx <= n_cx; r_cy <= n_cy; r_y <= n_y;
        r_xi <= n_xi; r_val <= n_val; r_a <= n_a; r_dy <= n_dy; r_dx <= n_dx;
        r_d <= n_d; r_dneg <= n_dneg; r_qneg <= n_qneg; r_prod <= n_prod;
        r_xd <= n_xd; r_rem <= n_rem; r_quo <= n_quo; r_ps <= n_ps; r_pe <= n_pe;
        r_res <= n_res;
    end

endmodule

FILE: rtl/polygon_scanline_span_fill.sv
// channel   direction  handshake                  payload
// input     in         i_in_valid / o_in_stall    i_op, i_x_coord, i_y_coord
// result    out        o_out_valid / i_out_stall  o_span_start .. o_overflow
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// clear and append pass through the queue to the engine, which does each in its
// idle state; a row request walks the n corners, runs the 35-step serial divider
// for each of the c crossings, places each crossing by insertion sort and then
// pairs the sorted crossings into spans, the divider setting the pace
// a four-word queue lets the host keep issuing while a row is being worked
// reset is synchronous, active low; it empties the queue, the polygon and the flag
// a stalled result sits in the output register while the engine runs on until its next result is ready
`include "assert_macros.svh"

module polygon_scanline_span_fill (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input words
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_op,
    input  logic signed [psf_pkg::COORD_BITS-1:0] i_x_coord,
    input  logic signed [psf_pkg::COORD_BITS-1:0] i_y_coord,
    // result words
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic signed [psf_pkg::COORD_BITS-1:0] o_span_start,
    output logic signed [psf_pkg::COORD_BITS-1:0] o_span_end,
    output logic signed [psf_pkg::COORD_BITS-1:0] o_row_y,
    output logic [31:0] o_color,
    output logic        o_has_span,
    output logic        o_last,
    output logic        o_overflow,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import psf_pkg::*;

    t_cfg    r_cfg;
    t_cmd    cmd;
    t_result res;
    logic    cmd_valid, cmd_pop;

    // config registers are always writable; the host must write them only while idle, the block does not enforce it
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_CLIP_LEFT:  r_cfg.clip_left  <= i_cfg_data[15:0];
                CFG_CLIP_RIGHT: r_cfg.clip_right <= i_cfg_data[15:0];
                CFG_FILL_COLOR: r_cfg.fill_color <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // front: takes words, drops the unused op, queues the rest
    psf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in_valid),
        .o_stall    (o_in_stall),
        .i_op       (i_op),
        .i_x        (i_x_coord),
        .i_y        (i_y_coord),
        .o_cmd_valid(cmd_valid),
        .o_cmd      (cmd),
        .i_cmd_pop  (cmd_pop)
    );

    // back: vertex store, edge walk, divider, sort and span pairing
    psf_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_valid(cmd_valid),
        .i_cmd      (cmd),
        .o_cmd_pop  (cmd_pop),
        .i_cfg      (r_cfg),
        .o_valid    (o_out_valid),
        .i_stall    (i_out_stall),
        .o_res      (res)
    );

    assign o_span_start = res.span_start;
    assign o_span_end   = res.span_end;
    assign o_row_y      = res.row_y;
    assign o_color      = res.color;
    assign o_has_span   = res.has_span;
    assign o_last       = res.last;
    assign o_overflow   = res.overflow;

    // an empty-row marker always closes its row
    `ASSERT_IMP(a_marker_last, i_clk, i_rst_n, o_out_valid && !o_has_span, o_last, "marker not last")
    // spans never come out reversed
    `ASSERT_IMP(a_span_order, i_clk, i_rst_n, o_out_valid && o_has_span, o_span_start <= o_span_end, "span reversed")
    // marker carries zero span ends
    `ASSERT_IMP(a_marker_zero, i_clk, i_rst_n, o_out_valid && !o_has_span, (o_span_start == 16'sd0) && (o_span_end == 16'sd0), "marker ends not zero")
    // a taken word that was not last is followed by more of the same row
    `ASSERT_NXT(a_row_cont, i_clk, i_rst_n, o_out_valid && !i_out_stall && !o_last, !o_out_valid || (o_row_y == $past(o_row_y)), "row changed mid-row")

endmodule
